// File: hw/rtl/srrf_pkg.sv
// Shared constants, types and codes of the sorted restriction run filter.
package srrf_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int MAX_RUN     = 16;
   localparam int RESULT_CAP  = 16;
   localparam int RUN_LIMIT   = (MAX_RUN < RESULT_CAP) ? MAX_RUN : RESULT_CAP;

   localparam int ADDR_W    = $clog2(TABLE_DEPTH);
   localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int RUN_W     = $clog2(RUN_LIMIT + 1);
   localparam int CFG_W     = 11;
   localparam int SLOT_W    = 10;
   localparam int KEY_W     = 21;
   localparam int MODE_W    = 12;
   localparam int PAYLOAD_W = 64;
   localparam int REC_W     = MODE_W + PAYLOAD_W;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH_RD,
      ST_SEARCH_CMP,
      ST_BACK_RD,
      ST_BACK_CMP,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_FINAL
   } state_type;

   typedef struct packed {
      logic                 found;
      logic [SLOT_W-1:0]    match_slot;
      logic [KEY_W-1:0]     match_edge_key;
      logic [MODE_W-1:0]    match_modes;
      logic [PAYLOAD_W-1:0] match_payload;
      logic                 truncated;
      logic                 last;
   } rsp_word_type;

endpackage

// File: hw/rtl/srrf_if.sv
// Request, response and register-write channel interfaces.
interface srrf_req_if
   import srrf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 opcode;
   logic [SLOT_W-1:0]    slot;
   logic [KEY_W-1:0]     edge_key;
   logic [MODE_W-1:0]    mode_mask;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, opcode, slot, edge_key, mode_mask, payload, input ready);
   modport sink   (input valid, opcode, slot, edge_key, mode_mask, payload, output ready);
endinterface

interface srrf_rsp_if
   import srrf_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic                 found;
   logic [SLOT_W-1:0]    match_slot;
   logic [KEY_W-1:0]     match_edge_key;
   logic [MODE_W-1:0]    match_modes;
   logic [PAYLOAD_W-1:0] match_payload;
   logic                 truncated;
   logic                 last;

   modport source (output valid, found, match_slot, match_edge_key, match_modes,
                   match_payload, truncated, last, input ready);
   modport sink   (input valid, found, match_slot, match_edge_key, match_modes,
                   match_payload, truncated, last, output ready);
endinterface

interface srrf_csr_if
   import srrf_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] entry_count;

   modport source (output valid, entry_count, input ready);
   modport sink   (input valid, entry_count, output ready);
endinterface

// File: hw/rtl/srrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module srrf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/sorted_restriction_run_filter_core.sv
// Top level of the sorted restriction run filter: search, back-up and run walk.
//
//   channel | dir | word
//   req_ch  | in  | opcode, slot, edge_key, mode_mask, payload
//   rsp_ch  | out | found, match_slot, match_edge_key, match_modes, match_payload,
//           |     | truncated, last
//   csr_ch  | in  | entry_count
//
// A write is stored in both memories when it is accepted in idle. A query makes
// search probes (at most log2(depth)+1), backs over records of equal key, walks the
// run and sends the final word; each probe, back-up step and walk step is a read
// state then a compare state, as the record memories register their read data.
// Reset is synchronous, holds both inputs not ready and clears control state and
// entry_count; table contents stay undefined until written. A stalled response
// holds the walk in place.
module sorted_restriction_run_filter_core
   import srrf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   srrf_req_if.sink   req_ch,
   srrf_rsp_if.source rsp_ch,
   srrf_csr_if.sink   csr_ch
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [MODE_W-1:0]  mask_ff, mask_in;
   logic [CNT_W-1:0]   low_ff, low_in;
   logic [CNT_W-1:0]   hi_ff, hi_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [RUN_W-1:0]   n_ff, n_in;
   logic               pend_valid_ff, pend_valid_in;
   rsp_word_type       pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_ff, rsp_in;

   logic               req_fire;
   logic               out_free;
   logic               wr_en;
   logic [CNT_W:0]     mid_sum;
   logic [ADDR_W-1:0]  mid;
   logic [KEY_W-1:0]   key_rd;
   logic [REC_W-1:0]   rec_rd;
   logic [MODE_W-1:0]  mode_rd;
   logic [PAYLOAD_W-1:0] payload_rd;
   logic               key_eq;
   logic               mode_hit;
   logic               run_full;
   rsp_word_type       cur_word;

   assign req_ch.ready = (state_ff == ST_IDLE) && !reset;
   assign csr_ch.ready = !reset;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign wr_en        = req_fire && (req_ch.opcode == OP_WRITE)
                         && (32'(req_ch.slot) < 32'(TABLE_DEPTH));

   assign mid_sum    = (CNT_W+1)'(low_ff) + (CNT_W+1)'(hi_ff) - (CNT_W+1)'(1);
   assign mid        = mid_sum[ADDR_W:1];
   assign mode_rd    = rec_rd[REC_W-1 -: MODE_W];
   assign payload_rd = rec_rd[PAYLOAD_W-1:0];
   assign key_eq     = (key_rd == key_ff);
   assign mode_hit   = ((mode_rd & mask_ff) != '0);
   assign run_full   = (n_ff == RUN_W'(RUN_LIMIT));

   always_comb begin
      cur_word                = '0;
      cur_word.found          = 1'b1;
      cur_word.match_slot     = SLOT_W'(addr_ff);
      cur_word.match_edge_key = key_rd;
      cur_word.match_modes    = mode_rd;
      cur_word.match_payload  = payload_rd;
   end

   srrf_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_ch.slot)),
      .wr_data (req_ch.edge_key),
      .rd_addr (addr_in),
      .rd_data (key_rd)
   );

   srrf_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_rec_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (ADDR_W'(req_ch.slot)),
      .wr_data ({req_ch.mode_mask, req_ch.payload}),
      .rd_addr (addr_in),
      .rd_data (rec_rd)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_ch.opcode == OP_QUERY)) begin
               state_in = ST_SEARCH_RD;
            end
         end
         ST_SEARCH_RD: begin
            state_in = (low_ff < hi_ff) ? ST_SEARCH_CMP : ST_FINAL;
         end
         ST_SEARCH_CMP: begin
            state_in = key_eq ? ST_BACK_RD : ST_SEARCH_RD;
         end
         ST_BACK_RD: begin
            state_in = (pos_ff != '0) ? ST_BACK_CMP : ST_WALK_RD;
         end
         ST_BACK_CMP: begin
            state_in = key_eq ? ST_BACK_RD : ST_WALK_RD;
         end
         ST_WALK_RD: begin
            state_in = (pos_ff < count_ff) ? ST_WALK_CMP : ST_FINAL;
         end
         ST_WALK_CMP: begin
            if (!key_eq) begin
               state_in = ST_FINAL;
            end else if (!mode_hit) begin
               state_in = ST_WALK_RD;
            end else if (pend_valid_ff && run_full) begin
               state_in = ST_FINAL;
            end else if (!pend_valid_ff || out_free) begin
               state_in = ST_WALK_RD;
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      count_in      = count_ff;
      key_in        = key_ff;
      mask_in       = mask_ff;
      low_in        = low_ff;
      hi_in         = hi_ff;
      pos_in        = pos_ff;
      addr_in       = addr_ff;
      n_in          = n_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_in        = rsp_ff;

      if (csr_ch.valid) begin
         if (32'(csr_ch.entry_count) > 32'(TABLE_DEPTH)) begin
            count_in = CNT_W'(TABLE_DEPTH);
         end else begin
            count_in = CNT_W'(csr_ch.entry_count);
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            key_in        = req_ch.edge_key;
            mask_in       = req_ch.mode_mask;
            low_in        = '0;
            hi_in         = count_ff;
            n_in          = '0;
            pend_valid_in = 1'b0;
         end
         ST_SEARCH_RD: begin
            addr_in = mid;
         end
         ST_SEARCH_CMP: begin
            if (key_eq) begin
               pos_in = CNT_W'(addr_ff);
            end else if (key_ff < key_rd) begin
               hi_in = CNT_W'(addr_ff);
            end else begin
               low_in = CNT_W'(addr_ff) + CNT_W'(1);
            end
         end
         ST_BACK_RD: begin
            addr_in = ADDR_W'(pos_ff - CNT_W'(1));
         end
         ST_BACK_CMP: begin
            if (key_eq) begin
               pos_in = CNT_W'(addr_ff);
            end
         end
         ST_WALK_RD: begin
            addr_in = pos_ff[ADDR_W-1:0];
         end
         ST_WALK_CMP: begin
            if (key_eq) begin
               if (!mode_hit) begin
                  pos_in = pos_ff + CNT_W'(1);
               end else if (pend_valid_ff && run_full) begin
                  pend_in.truncated = 1'b1;
               end else if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_in       = cur_word;
                  n_in          = n_ff + RUN_W'(1);
                  pos_in        = pos_ff + CNT_W'(1);
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_in = pend_ff;
               end else begin
                  rsp_in = '0;
               end
               rsp_in.last   = 1'b1;
               pend_valid_in = 1'b0;
            end
         end
         default: begin
            pend_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      key_ff  <= key_in;
      mask_ff <= mask_in;
      low_ff  <= low_in;
      hi_ff   <= hi_in;
      pos_ff  <= pos_in;
      addr_ff <= addr_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.found          = rsp_ff.found;
   assign rsp_ch.match_slot     = rsp_ff.match_slot;
   assign rsp_ch.match_edge_key = rsp_ff.match_edge_key;
   assign rsp_ch.match_modes    = rsp_ff.match_modes;
   assign rsp_ch.match_payload  = rsp_ff.match_payload;
   assign rsp_ch.truncated      = rsp_ff.truncated;
   assign rsp_ch.last           = rsp_ff.last;

   a_walk_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_CMP) |-> (addr_ff == pos_ff[ADDR_W-1:0]))
      else $error("walk compare address drifted from run position");

   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.truncated) |-> (rsp_ff.last && rsp_ff.found))
      else $error("truncated flag on a non-final or not-found word");

   a_miss_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.last && rsp_ff.match_payload == '0))
      else $error("not-found word is not a clean final word");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> ((n_ff != '0) && (n_ff <= RUN_W'(RUN_LIMIT))))
      else $error("run counter out of range while a word is held");

endmodule
